// File: rtl/core/buffer_cache_directory_top_macros.svh
// ----------------------------------------------------------------------------
// buffer_cache_directory_top_macros
// Assertion macros for the cache directory.
// ----------------------------------------------------------------------------
`ifndef BUFFER_CACHE_DIRECTORY_TOP_MACROS_SVH
`define BUFFER_CACHE_DIRECTORY_TOP_MACROS_SVH
`define BCD_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define BCD_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// File: rtl/core/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg
// Commands, status codes, sizes and control types of the cache directory.
// ----------------------------------------------------------------------------
package bcd_pkg;
  localparam int SLOTS     = 64;
  localparam int TAG_BITS  = 32;
  localparam int REF_BITS  = 8;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int CNT_BITS  = $clog2(SLOTS + 1);

  localparam logic [1:0] CMD_GET     = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_DIRTY   = 2'd2;
  localparam logic [1:0] CMD_CLEAN   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_NOT_REF  = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_NOT_FILL = 3'd4;

  typedef struct packed {
    logic load;
    logic look;
    logic update;
  } bcd_cmd_t;

  typedef struct packed {
    logic [REF_BITS-1:0] refs;
    logic                dirty;
    logic                listed;
  } bcd_meta_t;
endpackage

// File: rtl/core/bcd_if.sv
// ----------------------------------------------------------------------------
// bcd_req_if / bcd_rsp_if / bcd_cfg_if
// Valid/ready channels of the cache directory.
// ----------------------------------------------------------------------------
interface bcd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] block_number;
  logic [5:0]  slot;
  modport source (output valid, command, block_number, slot, input ready);
  modport sink (input valid, command, block_number, slot, output ready);
endinterface

interface bcd_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        hit;
  logic [5:0]  slot_out;
  logic        needs_read;
  logic        evicted;
  logic        newly_dirty;
  logic [7:0]  ref_count;
  logic [6:0]  free_count;
  logic [6:0]  dirty_count;
  logic [31:0] hits_total;
  logic [31:0] misses_total;
  modport source (output valid, status, hit, slot_out, needs_read, evicted, newly_dirty,
                  ref_count, free_count, dirty_count, hits_total, misses_total,
                  input ready);
  modport sink (input valid, status, hit, slot_out, needs_read, evicted, newly_dirty,
                ref_count, free_count, dirty_count, hits_total, misses_total,
                output ready);
endinterface

interface bcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/core/bcd_ctrl.sv
// ----------------------------------------------------------------------------
// bcd_ctrl
// Sequencer: accept, look up, update, present result.
// ----------------------------------------------------------------------------
module bcd_ctrl
  import bcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output bcd_cmd_t cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state, state_next;

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.look   = (state == S_LOOK);
  assign cmd.update = (state == S_UPD);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_LOOK;
      S_LOOK: state_next = S_UPD;
      S_UPD:  state_next = S_OUT;
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

// File: rtl/core/bcd_dp.sv
// ----------------------------------------------------------------------------
// bcd_dp
// Slot directory: tag match, refcounts, dirty marks, LRU free list, counters.
// ----------------------------------------------------------------------------
module bcd_dp
  import bcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  bcd_cmd_t    cmd,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,
  input  logic [1:0]  command,
  input  logic [31:0] block_number,
  input  logic [5:0]  slot,
  output logic [2:0]  status,
  output logic        hit,
  output logic [5:0]  slot_out,
  output logic        needs_read,
  output logic        evicted,
  output logic        newly_dirty,
  output logic [7:0]  ref_count,
  output logic [6:0]  free_count,
  output logic [6:0]  dirty_count,
  output logic [31:0] hits_total,
  output logic [31:0] misses_total
);
  localparam int SB = SLOT_BITS;
  localparam int CB = CNT_BITS;
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  logic [TAG_BITS-1:0] slot_tag [SLOTS];
  bcd_meta_t           meta_mem [SLOTS];
  logic [SB-1:0]       next_mem [SLOTS];
  logic [SB-1:0]       prev_mem [SLOTS];
  bcd_meta_t           meta_rd;
  logic [SB-1:0]       next_rd, prev_rd;
  logic [SB-1:0]       free_head, free_tail;
  logic [CB-1:0]       used_slots, free_slots, dirty_slots;
  logic [CB-1:0]       free_slots_next, dirty_slots_next;
  logic [6:0]          max_blocks;
  logic [1:0]          r_cmd;
  logic [TAG_BITS-1:0] r_tag;
  logic [5:0]          r_slot;
  logic [SLOTS-1:0]    match;
  logic                found;
  logic [SB-1:0]       found_idx;
  logic                sl_ok;
  logic [6:0]          cap;
  logic                room;
  logic [SB-1:0]       tgt;
  logic                pick_hit, pick_fresh, pick_evict, pick_none;
  logic [SB-1:0]       r_tgt;
  logic                r_hit, r_fresh, r_evict, r_none, r_bad;
  bcd_meta_t           cur, upd;
  logic                do_meta, do_unlink, do_link, mark, unmark;
  logic                tgt_head, tgt_tail;
  logic [2:0]          status_next;
  logic [REF_BITS-1:0] refs_out;

  always_comb begin
    found = 1'b0;
    found_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      match[i] = (CB'(i) < used_slots) && (slot_tag[i] == r_tag);
      if (match[i]) begin
        found = 1'b1;
        found_idx = SB'(i);
      end
    end
  end

  assign sl_ok = (CB'(r_slot) < used_slots);
  assign cap   = (max_blocks < CB'(SLOTS)) ? max_blocks : CB'(SLOTS);
  assign room  = (used_slots < cap);

  always_comb begin
    pick_hit = 1'b0;
    pick_fresh = 1'b0;
    pick_evict = 1'b0;
    pick_none = 1'b0;
    tgt = SB'(r_slot);
    if (r_cmd == CMD_GET) begin
      if (found) begin
        pick_hit = 1'b1;
        tgt = found_idx;
      end else if (room) begin
        pick_fresh = 1'b1;
        tgt = SB'(used_slots);
      end else if (free_slots != '0) begin
        pick_evict = 1'b1;
        tgt = free_head;
      end else begin
        pick_none = 1'b1;
        tgt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_cmd  <= command;
      r_tag  <= TAG_BITS'(block_number);
      r_slot <= slot;
    end
    if (cmd.look) begin
      meta_rd <= meta_mem[tgt];
      next_rd <= next_mem[tgt];
      prev_rd <= prev_mem[tgt];
      r_tgt   <= tgt;
      r_hit   <= pick_hit;
      r_fresh <= pick_fresh;
      r_evict <= pick_evict;
      r_none  <= pick_none;
      r_bad   <= (r_cmd != CMD_GET) && !sl_ok;
    end
  end

  assign cur      = r_fresh ? '0 : meta_rd;
  assign tgt_head = (r_tgt == free_head);
  assign tgt_tail = (r_tgt == free_tail);

  always_comb begin
    upd = cur;
    do_meta = 1'b0;
    do_unlink = 1'b0;
    do_link = 1'b0;
    mark = 1'b0;
    unmark = 1'b0;
    status_next = ST_OK;
    if (r_cmd == CMD_GET) begin
      if (r_none) status_next = ST_NO_SPACE;
      else begin
        do_meta = 1'b1;
        if (cur.refs == '0 && cur.listed) begin
          do_unlink = 1'b1;
          upd.listed = 1'b0;
        end
        if (cur.refs >= REF_MAX) status_next = ST_OVERFLOW;
        else upd.refs = cur.refs + 1'b1;
      end
    end else if (r_bad) begin
      status_next = ST_NOT_FILL;
    end else if (r_cmd == CMD_RELEASE) begin
      if (cur.refs == '0) status_next = ST_NOT_REF;
      else begin
        do_meta = 1'b1;
        upd.refs = cur.refs - 1'b1;
        if (upd.refs == '0 && !cur.dirty && !cur.listed) begin
          do_link = 1'b1;
          upd.listed = 1'b1;
        end
      end
    end else if (r_cmd == CMD_DIRTY) begin
      if (cur.refs == '0) status_next = ST_NOT_REF;
      else if (!cur.dirty) begin
        do_meta = 1'b1;
        upd.dirty = 1'b1;
        mark = 1'b1;
      end
    end else if (cur.dirty) begin
      do_meta = 1'b1;
      upd.dirty = 1'b0;
      unmark = 1'b1;
      if (cur.refs == '0 && !cur.listed) begin
        do_link = 1'b1;
        upd.listed = 1'b1;
      end
    end
  end

  assign refs_out         = (r_none || r_bad) ? '0 : upd.refs;
  assign free_slots_next  = free_slots + CB'(do_link) - CB'(do_unlink);
  assign dirty_slots_next = dirty_slots + CB'(mark) - CB'(unmark);

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (do_meta) meta_mem[r_tgt] <= upd;
      if (r_fresh || r_evict) slot_tag[r_tgt] <= r_tag;
      if (do_unlink && !tgt_head && !tgt_tail) begin
        next_mem[prev_rd] <= next_rd;
        prev_mem[next_rd] <= prev_rd;
      end else if (do_link) begin
        if (free_slots != '0) next_mem[free_tail] <= r_tgt;
        prev_mem[r_tgt] <= free_tail;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      status      <= status_next;
      hit         <= r_hit;
      slot_out    <= 6'(r_tgt);
      needs_read  <= r_fresh || r_evict;
      evicted     <= r_evict;
      newly_dirty <= mark;
      ref_count   <= 8'(refs_out);
      free_count  <= 7'(free_slots_next);
      dirty_count <= 7'(dirty_slots_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      free_tail <= '0;
      used_slots <= '0;
      free_slots <= '0;
      dirty_slots <= '0;
      hits_total <= '0;
      misses_total <= '0;
      max_blocks <= 7'd64;
    end else begin
      if (cfg_we) max_blocks <= cfg_data;
      if (cmd.update) begin
        if (r_cmd == CMD_GET) begin
          if (r_hit) hits_total <= hits_total + 32'd1;
          else misses_total <= misses_total + 32'd1;
        end
        if (r_fresh) used_slots <= used_slots + 1'b1;
        free_slots <= free_slots_next;
        dirty_slots <= dirty_slots_next;
        if (do_unlink) begin
          if (tgt_head && !tgt_tail) free_head <= next_rd;
          if (tgt_tail && !tgt_head) free_tail <= prev_rd;
        end else if (do_link) begin
          if (free_slots == '0) free_head <= r_tgt;
          free_tail <= r_tgt;
        end
      end
    end
  end
endmodule

// File: rtl/core/buffer_cache_directory_top.sv
// ----------------------------------------------------------------------------
// buffer_cache_directory_top
// Block cache directory with refcounts, dirty marks and an LRU free list.
//
// Channels: req (command, block_number, slot) in, rsp (one result per
// command) out, cfg writes max_blocks. All valid/ready; a transfer occurs
// when both are high.
// Sequence: a command is taken in state S_IDLE, looked up in S_LOOK (tag
// match, slot state and link reads), applied in S_UPD, and its result is
// offered in S_OUT. One command is in flight at a time, so a new command
// is taken only after the receiver has taken the last result.
// Reset: all slots empty, counters zero, max_blocks 64. Tag, slot state and
// link storage are not cleared; a slot's entries are written before use.
// Stall: the result holds on rsp until taken; req stays not ready.
// ----------------------------------------------------------------------------
`include "buffer_cache_directory_top_macros.svh"
module buffer_cache_directory_top
  import bcd_pkg::*;
(
  input logic clk,
  input logic rst,
  bcd_req_if.sink   req,
  bcd_rsp_if.source rsp,
  bcd_cfg_if.sink   cfg
);
  bcd_cmd_t cmd;

  assign cfg.ready = 1'b1;

  bcd_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd(cmd)
  );

  bcd_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .cfg_we(cfg.valid && cfg.ready), .cfg_data(cfg.data),
    .command(req.command), .block_number(req.block_number), .slot(req.slot),
    .status(rsp.status), .hit(rsp.hit), .slot_out(rsp.slot_out),
    .needs_read(rsp.needs_read), .evicted(rsp.evicted),
    .newly_dirty(rsp.newly_dirty), .ref_count(rsp.ref_count),
    .free_count(rsp.free_count), .dirty_count(rsp.dirty_count),
    .hits_total(rsp.hits_total), .misses_total(rsp.misses_total)
  );

  `BCD_ASSERT_IMP(a_excl, clk, rst, req.ready, !rsp.valid, "accept while result pending")
  `BCD_ASSERT_NEXT(a_exec, clk, rst, req.valid && req.ready, !rsp.valid && !req.ready,
                   "command not executing")
  `BCD_ASSERT_IMP(a_hit_rd, clk, rst, rsp.valid && rsp.hit, !rsp.needs_read,
                  "hit with read request")
endmodule
